// ===== rtl/fsg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsg_pkg
// Shared constants and command/status types for the falling sand grid step.
// ----------------------------------------------------------------------------
package fsg_pkg;
    localparam int DEF_GRID_WIDTH  = 64;
    localparam int DEF_GRID_HEIGHT = 64;
    localparam int DEF_GRAIN_SLOTS = 256;
    localparam int CNT_W           = 9;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_OUTSIDE  = 2'd2,
        ST_OCCUPIED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_SP_READ,
        OP_SP_PLACE,
        OP_ST_INIT,
        OP_ST_LOAD,
        OP_ST_PROBE_D,
        OP_ST_PROBE_L,
        OP_ST_PROBE_R,
        OP_ST_MOVE_CLR,
        OP_ST_MOVE_SET,
        OP_ST_SETTLE,
        OP_ST_DONE
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
        logic clear_done;
        logic hit;
    } stat_t;
endpackage
`default_nettype wire

// ===== rtl/fsg_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsg_datapath
// Occupancy bitmap, grain list and counters, driven by controller commands.
// ----------------------------------------------------------------------------
module fsg_datapath
    import fsg_pkg::*;
#(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
    parameter int GRAIN_SLOTS = DEF_GRAIN_SLOTS
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cmd_t             cmd,
    output stat_t                 stat,
    input  wire logic [7:0]       in_x,
    input  wire logic [7:0]       in_y,
    input  wire logic [CNT_W-1:0] limit_reg,
    output logic [1:0]            res_status,
    output logic [CNT_W-1:0]      res_moved,
    output logic [CNT_W-1:0]      res_settled,
    output logic [CNT_W-1:0]      res_dropped,
    output logic [CNT_W-1:0]      res_falling,
    output logic [CNT_W-1:0]      res_stationary
);
    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int GW    = (GRAIN_SLOTS > 1) ? $clog2(GRAIN_SLOTS) : 1;
    localparam int NW    = $clog2(GRAIN_SLOTS + 1);
    localparam int BW    = (NW > CNT_W) ? NW : CNT_W;

    logic           occ_mem [CELLS];
    logic [XW-1:0]  col_mem [GRAIN_SLOTS];
    logic [YW-1:0]  row_mem [GRAIN_SLOTS];

    logic [NW-1:0]  falling_reg, stationary_reg, idx_reg, keep_reg;
    logic [BW-1:0]  moved_reg, settled_reg, dropped_reg;
    logic [AW-1:0]  clr_reg;
    logic [XW-1:0]  gx_reg, nx_reg, probe_x_reg;
    logic [YW-1:0]  gy_reg;
    logic           occ_q_reg, go_reg, probe_valid_reg, probe_ok_reg;
    status_t        status_reg;

    logic [BW-1:0]  lim_eff;
    logic           xin, yin, row_ok, probe_ok, hit;
    logic [YW-1:0]  gy_below;
    logic [AW-1:0]  rd_addr, sp_addr, old_addr, new_addr;
    logic [XW-1:0]  px;

    always_comb begin
        lim_eff  = (BW'(limit_reg) < BW'(GRAIN_SLOTS)) ? BW'(limit_reg) : BW'(GRAIN_SLOTS);
        xin      = !in_x[7] && (32'(in_x) < 32'(GRID_WIDTH));
        yin      = !in_y[7] && (32'(in_y) < 32'(GRID_HEIGHT));
        gy_below = gy_reg + YW'(1);
        row_ok   = (32'(gy_reg) + 32'd1 < 32'(GRID_HEIGHT));
        case (cmd.op)
            OP_ST_PROBE_L: begin
                px       = gx_reg - XW'(1);
                probe_ok = row_ok && (gx_reg != '0);
            end
            OP_ST_PROBE_R: begin
                px       = gx_reg + XW'(1);
                probe_ok = row_ok && (32'(gx_reg) + 32'd1 < 32'(GRID_WIDTH));
            end
            default: begin
                px       = gx_reg;
                probe_ok = row_ok;
            end
        endcase
        sp_addr  = AW'(32'(in_y) * 32'(GRID_WIDTH) + 32'(in_x));
        old_addr = AW'(32'(gy_reg) * 32'(GRID_WIDTH) + 32'(gx_reg));
        new_addr = AW'(32'(gy_below) * 32'(GRID_WIDTH) + 32'(nx_reg));
        if (cmd.op == OP_SP_READ)
            rd_addr = sp_addr;
        else
            rd_addr = AW'(32'(gy_below) * 32'(GRID_WIDTH) + 32'(px));
        // A probe hits when the cell read in the previous cycle was in range and empty.
        hit = probe_valid_reg && probe_ok_reg && !occ_q_reg;
        stat.walk_done  = (idx_reg >= falling_reg);
        stat.clear_done = (32'(clr_reg) == 32'(CELLS - 1));
        stat.hit        = hit;
    end

    always_ff @(posedge aclk) begin
        occ_q_reg <= occ_mem[rd_addr];
        case (cmd.op)
            OP_CLEAR: begin
                occ_mem[clr_reg] <= 1'b0;
                clr_reg <= clr_reg + AW'(1);
            end
            OP_SP_PLACE: begin
                moved_reg <= '0;
                settled_reg <= '0;
                dropped_reg <= '0;
                if (BW'(falling_reg) >= lim_eff) status_reg <= ST_FULL;
                else if (!(xin && yin))          status_reg <= ST_OUTSIDE;
                else if (occ_q_reg)              status_reg <= ST_OCCUPIED;
                else begin
                    status_reg <= ST_OK;
                    occ_mem[sp_addr] <= 1'b1;
                    col_mem[GW'(falling_reg)] <= XW'(in_x);
                    row_mem[GW'(falling_reg)] <= YW'(in_y);
                    falling_reg <= falling_reg + NW'(1);
                end
            end
            OP_ST_INIT: begin
                status_reg <= ST_OK;
                moved_reg <= '0;
                settled_reg <= '0;
                dropped_reg <= '0;
                idx_reg <= '0;
                keep_reg <= '0;
            end
            OP_ST_LOAD: begin
                gx_reg <= col_mem[GW'(idx_reg)];
                gy_reg <= row_mem[GW'(idx_reg)];
            end
            OP_ST_MOVE_CLR: begin
                occ_mem[old_addr] <= 1'b0;
                col_mem[GW'(keep_reg)] <= nx_reg;
                row_mem[GW'(keep_reg)] <= gy_below;
                keep_reg <= keep_reg + NW'(1);
                idx_reg <= idx_reg + NW'(1);
                moved_reg <= moved_reg + BW'(1);
            end
            OP_ST_MOVE_SET: occ_mem[new_addr] <= 1'b1;
            OP_ST_SETTLE: begin
                idx_reg <= idx_reg + NW'(1);
                if (BW'(stationary_reg) < lim_eff) begin
                    stationary_reg <= stationary_reg + NW'(1);
                    settled_reg <= settled_reg + BW'(1);
                end else begin
                    dropped_reg <= dropped_reg + BW'(1);
                end
            end
            OP_ST_DONE: falling_reg <= keep_reg;
            default: ;
        endcase
        probe_valid_reg <= cmd.op inside {OP_ST_PROBE_D, OP_ST_PROBE_L, OP_ST_PROBE_R};
        probe_ok_reg    <= probe_ok;
        probe_x_reg     <= px;
        // Only the first hit of a grain picks its target column.
        if (cmd.op == OP_ST_LOAD) begin
            go_reg <= 1'b0;
        end else if (hit && !go_reg) begin
            go_reg <= 1'b1;
            nx_reg <= probe_x_reg;
        end
        if (!aresetn) begin
            falling_reg <= '0;
            stationary_reg <= '0;
            clr_reg <= '0;
            probe_valid_reg <= 1'b0;
            go_reg <= 1'b0;
            status_reg <= ST_OK;
            moved_reg <= '0;
            settled_reg <= '0;
            dropped_reg <= '0;
        end
    end

    assign res_status     = status_reg;
    assign res_moved      = moved_reg[CNT_W-1:0];
    assign res_settled    = settled_reg[CNT_W-1:0];
    assign res_dropped    = dropped_reg[CNT_W-1:0];
    assign res_falling    = CNT_W'(falling_reg);
    assign res_stationary = CNT_W'(stationary_reg);
endmodule
`default_nettype wire

// ===== rtl/fsg_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsg_ctrl
// Sequencer for clearing, spawning and the grain walk.
// ----------------------------------------------------------------------------
module fsg_ctrl
    import fsg_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    input  wire logic  in_command,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    output cmd_t       cmd,
    input  wire stat_t stat
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SP_READ, S_SP_PLACE, S_ST_INIT, S_LOAD, S_PD, S_PL, S_PR,
        S_PW, S_MOVE_CLR, S_MOVE_SET, S_SETTLE, S_DONE, S_OUT
    } state_t;
    state_t state_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb begin
        case (state_reg)
            S_CLEAR:    cmd.op = OP_CLEAR;
            S_SP_READ:  cmd.op = OP_SP_READ;
            S_SP_PLACE: cmd.op = OP_SP_PLACE;
            S_ST_INIT:  cmd.op = OP_ST_INIT;
            S_LOAD:     cmd.op = OP_ST_LOAD;
            S_PD:       cmd.op = OP_ST_PROBE_D;
            S_PL:       cmd.op = OP_ST_PROBE_L;
            S_PR:       cmd.op = OP_ST_PROBE_R;
            S_MOVE_CLR: cmd.op = OP_ST_MOVE_CLR;
            S_MOVE_SET: cmd.op = OP_ST_MOVE_SET;
            S_SETTLE:   cmd.op = OP_ST_SETTLE;
            S_DONE:     cmd.op = OP_ST_DONE;
            default:    cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            case (state_reg)
                S_CLEAR:    if (stat.clear_done) state_reg <= S_IDLE;
                S_IDLE:     if (in_valid) state_reg <= in_command ? S_ST_INIT : S_SP_READ;
                S_SP_READ:  state_reg <= S_SP_PLACE;
                S_SP_PLACE: state_reg <= S_OUT;
                S_ST_INIT:  state_reg <= S_LOAD;
                S_LOAD:     state_reg <= stat.walk_done ? S_DONE : S_PD;
                S_PD:       state_reg <= S_PL;
                S_PL:       state_reg <= stat.hit ? S_MOVE_CLR : S_PR;
                S_PR:       state_reg <= stat.hit ? S_MOVE_CLR : S_PW;
                S_PW:       state_reg <= stat.hit ? S_MOVE_CLR : S_SETTLE;
                S_MOVE_CLR: state_reg <= S_MOVE_SET;
                S_MOVE_SET: state_reg <= S_LOAD;
                S_SETTLE:   state_reg <= S_LOAD;
                S_DONE:     state_reg <= S_OUT;
                S_OUT:      if (out_ready) state_reg <= S_IDLE;
                default:    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/falling_sand_grid_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// falling_sand_grid_step
// Falling sand automaton: spawns grains and walks the falling list per step.
// ----------------------------------------------------------------------------
// Sequence: a spawn reads its cell, then places the grain and offers the
// result beat. A step clears its counters, then for each falling grain loads
// it and probes down, down-left and down-right in turn; the first hit moves
// the grain, else it settles or drops. Throughput: one item at a time; a new
// beat is taken the cycle after the result beat is accepted. Reset:
// synchronous, active low; the bitmap is then cleared with no input taken.
// ----------------------------------------------------------------------------
module falling_sand_grid_step
    import fsg_pkg::*;
#(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
    parameter int GRAIN_SLOTS = DEF_GRAIN_SLOTS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,  // [7:0] cell_x, [15:8] cell_y
    input  wire logic        s_tuser,  // [0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,  // [1:0] spawn_status, [10:2] moved,
                                       // [19:11] settled, [28:20] dropped,
                                       // [37:29] falling_total,
                                       // [46:38] stationary_total
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data  // grain_limit
);
    cmd_t  cmd;
    stat_t stat;
    logic [CNT_W-1:0] limit_reg;
    logic [1:0] r_st;
    logic [CNT_W-1:0] r_mv, r_se, r_dr, r_fa, r_sta;
    logic [7:0] x_reg, y_reg;

    // Capture the input beat so the datapath sees its cell for the whole item.
    // The command itself is only needed by the controller at the accepting edge.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            x_reg <= s_tdata[7:0];
            y_reg <= s_tdata[15:8];
        end
        if (!aresetn) limit_reg <= 9'd256;
        else if (cfg_valid) limit_reg <= cfg_data;
    end
    assign cfg_ready = 1'b1;

    // The controller sequences each item; the datapath holds all grid state.
    fsg_ctrl u_ctrl (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_command(s_tuser),
        .in_ready(s_tready), .out_valid(m_tvalid), .out_ready(m_tready),
        .cmd, .stat
    );

    fsg_datapath #(
        .GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT), .GRAIN_SLOTS(GRAIN_SLOTS)
    ) u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .in_x(x_reg), .in_y(y_reg), .limit_reg,
        .res_status(r_st), .res_moved(r_mv), .res_settled(r_se),
        .res_dropped(r_dr), .res_falling(r_fa), .res_stationary(r_sta)
    );

    // Result fields stay registered in the datapath, so the beat is steady while held.
    assign m_tdata = {1'b0, r_sta, r_fa, r_dr, r_se, r_mv, r_st};
endmodule
`default_nettype wire

// ===== rtl/fsg_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fsg_checker
// Port-level checks on the falling sand grid step.
// ----------------------------------------------------------------------------
module fsg_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input taken while result pending");
    a_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("second beat taken");
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != 2'd0 |-> m_tdata[28:2] == 27'd0)
        else $error("rejected spawn reports movement");
endmodule

bind falling_sand_grid_step fsg_checker u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire

// ===== test/falling_sand_grid_step_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// falling_sand_grid_step_checker
// Watches the input, result and limit channels of the falling sand block,
// keeps its own copy of the grid and grain list, and compares every result
// beat field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module falling_sand_grid_step_checker
    import fsg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [15:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [8:0]  cfg_data,
    output int               fail_count,
    output int               pending_results
);
    localparam int GW = DEF_GRID_WIDTH;
    localparam int GH = DEF_GRID_HEIGHT;

    typedef struct packed {
        logic [8:0] stationary_total;
        logic [8:0] falling_total;
        logic [8:0] dropped;
        logic [8:0] settled;
        logic [8:0] moved;
        status_t    status;
    } grain_report_t;

    bit            grid [GW*GH];
    int            col_list [DEF_GRAIN_SLOTS];
    int            row_list [DEF_GRAIN_SLOTS];
    int            falling_n;
    int            stationary_n;
    int            limit_reg;
    grain_report_t report_queue [$];

    function automatic bit cell_full(int x, int y);
        return grid[y*GW + x];
    endfunction

    function automatic grain_report_t predict_item(bit step, logic [7:0] xb, logic [7:0] yb);
        grain_report_t r;
        int lim, x, y, keep, gx, gy, nx;
        bit go;
        r = '0;
        lim = (limit_reg < DEF_GRAIN_SLOTS) ? limit_reg : DEF_GRAIN_SLOTS;
        if (!step) begin
            x = $signed(xb);
            y = $signed(yb);
            if (falling_n >= lim) begin
                r.status = ST_FULL;
            end else if (x < 0 || x >= GW || y < 0 || y >= GH) begin
                r.status = ST_OUTSIDE;
            end else if (cell_full(x, y)) begin
                r.status = ST_OCCUPIED;
            end else begin
                r.status = ST_OK;
                grid[y*GW + x] = 1'b1;
                col_list[falling_n] = x;
                row_list[falling_n] = y;
                falling_n++;
            end
        end else begin
            r.status = ST_OK;
            keep = 0;
            for (int i = 0; i < falling_n; i++) begin
                gx = col_list[i];
                gy = row_list[i];
                nx = gx;
                go = 1'b0;
                if (gy + 1 < GH) begin
                    if (!cell_full(gx, gy + 1)) begin
                        go = 1'b1;
                    end else if (gx >= 1 && !cell_full(gx - 1, gy + 1)) begin
                        nx = gx - 1;
                        go = 1'b1;
                    end else if (gx + 1 < GW && !cell_full(gx + 1, gy + 1)) begin
                        nx = gx + 1;
                        go = 1'b1;
                    end
                end
                if (go) begin
                    grid[gy*GW + gx] = 1'b0;
                    grid[(gy+1)*GW + nx] = 1'b1;
                    col_list[keep] = nx;
                    row_list[keep] = gy + 1;
                    keep++;
                    r.moved++;
                end else if (stationary_n < lim) begin
                    stationary_n++;
                    r.settled++;
                end else begin
                    r.dropped++;
                end
            end
            falling_n = keep;
        end
        r.falling_total = falling_n[8:0];
        r.stationary_total = stationary_n[8:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        grain_report_t want, got;
        if (!aresetn) begin
            grid = '{default: 1'b0};
            falling_n = 0;
            stationary_n = 0;
            limit_reg = 256;
            report_queue.delete();
            fail_count <= 0;
            pending_results <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                limit_reg = cfg_data;
            if (s_tvalid && s_tready)
                report_queue.push_back(predict_item(s_tuser, s_tdata[7:0], s_tdata[15:8]));
            if (m_tvalid && m_tready) begin
                got = m_tdata[46:0];
                if (report_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result beat %h", m_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = report_queue.pop_front();
                    if (got !== want || m_tdata[47] !== 1'b0) begin
                        if (fail_count < 10)
                            $display("mismatch: want st=%0d mv=%0d se=%0d dr=%0d fa=%0d sta=%0d,",
                                want.status, want.moved, want.settled, want.dropped,
                                want.falling_total, want.stationary_total,
                                " got st=%0d mv=%0d se=%0d dr=%0d fa=%0d sta=%0d",
                                got.status, got.moved, got.settled, got.dropped,
                                got.falling_total, got.stationary_total);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_results <= report_queue.size();
        end
    end
endmodule

// ===== test/falling_sand_grid_step_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// falling_sand_grid_step_tb
// Drives spawn and step beats into the falling sand block under several
// grain limits, with random gaps and back-pressure, and leaves prediction
// and comparison to the checker.
// ----------------------------------------------------------------------------
module falling_sand_grid_step_tb;
    import fsg_pkg::*;

    localparam bit CMD_SPAWN = 1'b0;
    localparam bit CMD_STEP  = 1'b1;
    localparam int CYCLE_LIMIT = 3_000_000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // [7:0] cell_x, [15:8] cell_y
    logic        s_tuser;    // [0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // status, moved, settled, dropped, falling, stationary
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;
    int          fail_count;
    int          pending_results;
    int          cycle_count;

    // Flags steering the stimulus: a long result hold-off and a stretch without stalls or input gaps.
    bit          hold_results;
    bit          steady_phase;

    falling_sand_grid_step dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    falling_sand_grid_step_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // The run is cut short if the block ever hangs.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("falling_sand_grid_step_tb: FAIL");
                $finish;
            end
        end
    end

    // Result side: random stalls, none during the steady phase, and a long
    // hold-off counted in cycles whenever the stimulus asks for one.
    initial begin
        int held;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_results) begin
                m_tready <= 1'b0;
                held = 0;
                while (held < 400) begin
                    @(posedge aclk);
                    held++;
                end
                hold_results = 1'b0;
            end else begin
                m_tready <= steady_phase || ($urandom_range(99) >= 30);
            end
        end
    end

    // Offers one beat, with a random gap before it, and waits for acceptance.
    // The valid stays up until the next beat or a drain takes it down.
    task automatic send_beat(bit cmd, logic [7:0] x, logic [7:0] y);
        if (!steady_phase && $urandom_range(99) < 30) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Lets every outstanding result drain, then waits out a long step.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
    endtask

    // Writes the grain limit while the block is idle.
    task automatic write_limit(logic [8:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly spawns in a narrow band of columns so grains pile up and
    // collide, with some spawns anywhere in the signed range and some steps.
    task automatic random_items(int count);
        logic [7:0] x, y;
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                send_beat(CMD_STEP, 8'($urandom), 8'($urandom));
            end else if (pick < 85) begin
                x = 8'($urandom_range(20, 27));
                y = 8'($urandom_range(0, 63));
                send_beat(CMD_SPAWN, x, y);
            end else begin
                send_beat(CMD_SPAWN, 8'($urandom), 8'($urandom));
            end
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        hold_results = 1'b0;
        steady_phase = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part: corners, out of grid on each side, an occupied cell,
        // a three-grain heap that tests down, down-left and down-right, and a
        // grain on the bottom row that settles at once.
        send_beat(CMD_SPAWN, 8'd0, 8'd0);
        send_beat(CMD_SPAWN, 8'd63, 8'd63);
        send_beat(CMD_SPAWN, 8'd0, 8'd0);
        send_beat(CMD_SPAWN, 8'd64, 8'd5);
        send_beat(CMD_SPAWN, 8'hFF, 8'd5);
        send_beat(CMD_SPAWN, 8'd5, 8'h80);
        send_beat(CMD_SPAWN, 8'h7F, 8'h7F);
        send_beat(CMD_SPAWN, 8'd30, 8'd64);
        send_beat(CMD_SPAWN, 8'd30, 8'd62);
        send_beat(CMD_SPAWN, 8'd30, 8'd61);
        send_beat(CMD_SPAWN, 8'd30, 8'd60);
        send_beat(CMD_STEP, 8'hFF, 8'hFF);
        send_beat(CMD_STEP, 8'h00, 8'h00);
        send_beat(CMD_STEP, 8'h00, 8'h00);
        send_beat(CMD_STEP, 8'h00, 8'h00);

        // Limit of zero: every spawn is rejected as full.
        write_limit(9'd0);
        send_beat(CMD_SPAWN, 8'd10, 8'd10);
        send_beat(CMD_STEP, 8'd0, 8'd0);

        // Small limit, then lowered below the falling count.
        write_limit(9'd3);
        for (int i = 0; i < 4; i++) send_beat(CMD_SPAWN, 8'(40 + i), 8'd0);
        write_limit(9'd1);
        send_beat(CMD_SPAWN, 8'd50, 8'd0);
        for (int i = 0; i < 3; i++) send_beat(CMD_STEP, 8'd0, 8'd0);

        // Largest register value, which the block clamps to the list size.
        write_limit(9'h1FF);
        random_items(150);

        // Result side holds off while spawn and step beats keep coming.
        hold_results = 1'b1;
        random_items(40);
        drain_results();

        write_limit(9'd256);
        steady_phase = 1'b1;
        random_items(150);
        steady_phase = 1'b0;
        random_items(100);

        write_limit(9'd17);
        random_items(150);

        write_limit(9'd1);
        random_items(100);

        drain_results();
        if (fail_count == 0) begin
            $display("falling_sand_grid_step_tb: PASS");
        end else begin
            $display("falling_sand_grid_step_tb: FAIL");
        end
        $finish;
    end
endmodule
